// ===== hw/rtl/ngr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the nearest grid resampler.
package ngr_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 10;
    localparam int PTS_W       = 11;
    localparam int CMD_DEPTH   = 4;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PTS   = 2'd1;
    localparam logic [1:0] ST_INDEX = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_RIGHT  = 2'd1;
    localparam logic [1:0] CFG_POINTS = 2'd2;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] axis;
        logic signed [DATA_W-1:0] dep;
        logic [IDX_W-1:0]         idx;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        logic [PTS_W-1:0]         points;
        logic                     wr;
    } cfg_t;

endpackage

// ===== hw/rtl/nearest_grid_resampler.sv =====
`timescale 1ns / 1ps
// Nearest grid resampler: configuration registers, front end and back end.
//
// Usage: items enter through push/full (func, axis_value, dependent_value,
// grid_index). func clear empties the store, load appends a sorted sample
// pair, query resolves grid point grid_index; other codes are dropped.
// Each query gives one result (nearest_axis, nearest_dependent, status),
// read through empty/pop in order. Configuration (grid_left, grid_right,
// grid_points) is written through cfg_we/cfg_index/cfg_data while idle.
// Items wait in a four-entry command queue; the back end works on one at a
// time. A load is dropped once the store holds 1024 pairs. A searching
// query runs a binary search over the axis store; the first searching
// query after reset or a configuration write first runs the bit-serial
// step divider. Reset empties both queues and the store count.
// While the receiver stalls, up to two results wait; a query is then held
// in the command queue, and full rises once that queue fills.
module nearest_grid_resampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        func,
    input  logic signed [ngr_pkg::DATA_W-1:0] axis_value,
    input  logic signed [ngr_pkg::DATA_W-1:0] dependent_value,
    input  logic [ngr_pkg::IDX_W-1:0]         grid_index,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [ngr_pkg::DATA_W-1:0] nearest_axis,
    output logic signed [ngr_pkg::DATA_W-1:0] nearest_dependent,
    output logic [1:0]                        status,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [ngr_pkg::DATA_W-1:0]        cfg_data
);

    logic signed [ngr_pkg::DATA_W-1:0] left_reg;
    logic signed [ngr_pkg::DATA_W-1:0] right_reg;
    logic [ngr_pkg::PTS_W-1:0]         points_reg;
    ngr_pkg::cfg_t                     cfg;
    logic                              cmd_valid;
    ngr_pkg::cmd_t                     cmd;
    logic                              cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            right_reg  <= '0;
            points_reg <= ngr_pkg::PTS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ngr_pkg::CFG_LEFT:   left_reg   <= cfg_data;
                ngr_pkg::CFG_RIGHT:  right_reg  <= cfg_data;
                ngr_pkg::CFG_POINTS: points_reg <= cfg_data[ngr_pkg::PTS_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg = '{left: left_reg, right: right_reg, points: points_reg, wr: cfg_we};

    ngr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .func            (func),
        .axis_value      (axis_value),
        .dependent_value (dependent_value),
        .grid_index      (grid_index),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    ngr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_pop           (cmd_pop),
        .empty             (empty),
        .pop               (pop),
        .nearest_axis      (nearest_axis),
        .nearest_dependent (nearest_dependent),
        .status            (status)
    );

endmodule

// ===== hw/rtl/ngr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input items, drops unused codes and queues commands.
module ngr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        func,
    input  logic signed [ngr_pkg::DATA_W-1:0] axis_value,
    input  logic signed [ngr_pkg::DATA_W-1:0] dependent_value,
    input  logic [ngr_pkg::IDX_W-1:0]         grid_index,
    output logic                              cmd_valid,
    output ngr_pkg::cmd_t                     cmd,
    input  logic                              cmd_pop
);

    localparam int PTR_W = $clog2(ngr_pkg::CMD_DEPTH);

    ngr_pkg::cmd_t    q_reg [ngr_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             enq;
    logic             deq;

    assign full      = (cnt_reg == (PTR_W+1)'(ngr_pkg::CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rp_reg];

    // unused function codes are taken but never queued
    assign enq = push && !full && (func != ngr_pkg::FUNC_NONE);
    assign deq = cmd_pop && cmd_valid;

    always_comb
    begin
        wp_next  = enq ? wp_reg + PTR_W'(1) : wp_reg;
        rp_next  = deq ? rp_reg + PTR_W'(1) : rp_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(enq) - (PTR_W+1)'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wp_reg] <= '{func: func, axis: axis_value, dep: dependent_value,
                               idx: grid_index};
        end
    end

endmodule

// ===== hw/rtl/ngr_back.sv =====
`timescale 1ns / 1ps
// Back end: sample stores, step divider, grid multiply, search and result queue.
module ngr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ngr_pkg::cfg_t                     cfg,
    input  logic                              cmd_valid,
    input  ngr_pkg::cmd_t                     cmd,
    output logic                              cmd_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [ngr_pkg::DATA_W-1:0] nearest_axis,
    output logic signed [ngr_pkg::DATA_W-1:0] nearest_dependent,
    output logic [1:0]                        status
);

    localparam int AW = ngr_pkg::ADDR_W;
    localparam int CW = ngr_pkg::CNT_W;
    localparam int DW = ngr_pkg::DATA_W;
    localparam int KW = ngr_pkg::IDX_W;
    localparam int PW = ngr_pkg::PTS_W;
    localparam int RW = PW - 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_GADD  = 4'd3;
    localparam logic [3:0] S_MID   = 4'd4;
    localparam logic [3:0] S_PROBE = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_POS   = 4'd7;
    localparam logic [3:0] S_PC    = 4'd8;
    localparam logic [3:0] S_PP    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    typedef struct packed {
        logic signed [DW-1:0] axis;
        logic signed [DW-1:0] dep;
        logic [1:0]           st;
    } res_t;

    // sample stores
    logic signed [DW-1:0] axis_mem [ngr_pkg::MAX_SAMPLES];
    logic signed [DW-1:0] dep_mem  [ngr_pkg::MAX_SAMPLES];
    logic signed [DW-1:0] axis_q;
    logic signed [DW-1:0] dep_q;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;

    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [DW-1:0]        step_reg, step_next;
    logic                 step_ok_reg, step_ok_next;
    logic [4:0]           div_cnt_reg, div_cnt_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        quo_reg, quo_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [DW+KW-1:0]     prod_reg, prod_next;
    logic signed [DW-1:0] lo_reg, lo_next;
    logic signed [DW-1:0] g_reg, g_next;
    logic signed [DW-1:0] a0_reg, a0_next;
    logic                 desc_reg, desc_next;
    logic [CW-1:0]        first_reg, first_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [DW-1:0]        dc_reg, dc_next;

    // result queue
    res_t                 res_q_reg [2];
    logic                 res_wp_reg, res_rp_reg;
    logic [1:0]           res_cnt_reg;
    logic                 res_push;
    res_t                 res_in;
    logic                 res_full;
    logic                 res_pop;

    logic signed [DW-1:0] lo_c, hi_c;
    logic [DW-1:0]        diff_c;
    logic [RW:0]          dvs_c;
    logic [RW:0]          rem_sh;
    logic [CW-1:0]        half_c, mid_c, pm_c, pos_c, pos_sel;
    logic [DW-1:0]        dist_c;

    function automatic logic [DW-1:0] mag32(input logic signed [DW-1:0] v);
        mag32 = v[DW-1] ? (~v + DW'(1)) : v;
    endfunction

    function automatic logic [DW-1:0] abs_gap(input logic signed [DW-1:0] a,
                                              input logic signed [DW-1:0] g);
        logic [DW:0] d;
        d       = {1'b0, mag32(a)} - {1'b0, mag32(g)};
        abs_gap = d[DW] ? DW'(~d + (DW+1)'(1)) : d[DW-1:0];
    endfunction

    // physical address of a logical position, reversed for a descending store
    function automatic logic [CW-1:0] phys(input logic [CW-1:0] p, input logic dsc,
                                           input logic [CW-1:0] n);
        phys = dsc ? (n - CW'(1) - p) : p;
    endfunction

    assign empty    = (res_cnt_reg == 2'd0);
    assign res_full = (res_cnt_reg == 2'd2);
    assign res_pop  = pop && !empty;
    assign nearest_axis      = res_q_reg[res_rp_reg].axis;
    assign nearest_dependent = res_q_reg[res_rp_reg].dep;
    assign status            = res_q_reg[res_rp_reg].st;

    always_comb
    begin
        if (cfg.right < cfg.left)
        begin
            lo_c = cfg.right;
            hi_c = cfg.left;
        end
        else
        begin
            lo_c = cfg.left;
            hi_c = cfg.right;
        end
        diff_c = DW'(hi_c - lo_c);
        dvs_c  = cfg.points - PW'(1);
        rem_sh = {rem_reg, quo_reg[DW-1]};
        half_c = len_reg >> 1;
        mid_c  = first_reg + half_c;
        pm_c   = phys(mid_c, desc_reg, count_reg);
        pos_c  = (first_reg >= count_reg) ? count_reg - CW'(1) : first_reg;
        dist_c = abs_gap(axis_q, g_reg);
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        step_ok_next = step_ok_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        k_next       = k_reg;
        prod_next    = prod_reg;
        lo_next      = lo_reg;
        g_next       = g_reg;
        a0_next      = a0_reg;
        desc_next    = desc_reg;
        first_next   = first_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        dc_next      = dc_reg;
        pos_sel      = pos_reg;
        rd_addr      = '0;
        mem_we       = 1'b0;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_in       = '{axis: '0, dep: '0, st: ngr_pkg::ST_OK};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.func)
                        ngr_pkg::FUNC_CLEAR:
                        begin
                            cmd_pop    = 1'b1;
                            count_next = '0;
                        end
                        ngr_pkg::FUNC_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            if (count_reg < CW'(ngr_pkg::MAX_SAMPLES))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ngr_pkg::FUNC_QUERY:
                        begin
                            // hold the query until the result queue has room
                            if (!res_full)
                            begin
                                cmd_pop = 1'b1;
                                k_next  = cmd.idx;
                                lo_next = lo_c;
                                if (count_reg == '0)
                                begin
                                    res_push  = 1'b1;
                                    res_in.st = ngr_pkg::ST_EMPTY;
                                end
                                else if (CW'(cfg.points) > count_reg)
                                begin
                                    res_push  = 1'b1;
                                    res_in.st = ngr_pkg::ST_PTS;
                                end
                                else if (PW'(cmd.idx) >= cfg.points)
                                begin
                                    res_push  = 1'b1;
                                    res_in.st = ngr_pkg::ST_INDEX;
                                end
                                else if (CW'(cfg.points) == count_reg)
                                begin
                                    rd_addr    = AW'(cmd.idx);
                                    state_next = S_OUT;
                                end
                                else if (step_ok_reg)
                                begin
                                    state_next = S_MUL;
                                end
                                else
                                begin
                                    rem_next     = '0;
                                    quo_next     = diff_c;
                                    div_cnt_next = '0;
                                    state_next   = S_DIV;
                                end
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                // one restoring quotient bit per cycle
                if (rem_sh >= dvs_c)
                begin
                    rem_next = RW'(rem_sh - dvs_c);
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = RW'(rem_sh);
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(DW - 1))
                begin
                    step_next    = (cfg.points == PW'(1)) ? '0 : quo_next;
                    step_ok_next = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = k_reg * step_reg;
                rd_addr    = '0;
                state_next = S_GADD;
            end
            S_GADD:
            begin
                g_next     = lo_reg + $signed(prod_reg[DW-1:0]);
                a0_next    = axis_q;
                rd_addr    = AW'(count_reg >> 1);
                state_next = S_MID;
            end
            S_MID:
            begin
                desc_next  = (a0_reg > axis_q);
                first_next = '0;
                len_next   = count_reg;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (len_reg == '0)
                begin
                    state_next = S_POS;
                end
                else
                begin
                    rd_addr    = AW'(pm_c);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (axis_q < g_reg)
                begin
                    first_next = mid_c + CW'(1);
                    len_next   = len_reg - half_c - CW'(1);
                end
                else
                begin
                    len_next = half_c;
                end
                state_next = S_PROBE;
            end
            S_POS:
            begin
                pos_next = pos_c;
                if (pos_c == '0)
                begin
                    rd_addr    = AW'(phys(pos_c, desc_reg, count_reg));
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr    = AW'(phys(pos_c, desc_reg, count_reg));
                    state_next = S_PC;
                end
            end
            S_PC:
            begin
                dc_next    = dist_c;
                rd_addr    = AW'(phys(pos_reg - CW'(1), desc_reg, count_reg));
                state_next = S_PP;
            end
            S_PP:
            begin
                // take the previous entry only when strictly closer
                if (dc_reg > dist_c)
                begin
                    pos_sel = pos_reg - CW'(1);
                end
                rd_addr    = AW'(phys(pos_sel, desc_reg, count_reg));
                state_next = S_OUT;
            end
            S_OUT:
            begin
                res_push   = 1'b1;
                res_in     = '{axis: axis_q, dep: dep_q, st: ngr_pkg::ST_OK};
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new bound or point count invalidates the cached step
        if (cfg.wr)
        begin
            step_ok_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            step_ok_reg <= 1'b0;
            res_wp_reg  <= 1'b0;
            res_rp_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_ok_reg <= step_ok_next;
            res_wp_reg  <= res_push ? ~res_wp_reg : res_wp_reg;
            res_rp_reg  <= res_pop ? ~res_rp_reg : res_rp_reg;
            res_cnt_reg <= res_cnt_reg + 2'(res_push) - 2'(res_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        div_cnt_reg <= div_cnt_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        k_reg       <= k_next;
        prod_reg    <= prod_next;
        lo_reg      <= lo_next;
        g_reg       <= g_next;
        a0_reg      <= a0_next;
        desc_reg    <= desc_next;
        first_reg   <= first_next;
        len_reg     <= len_next;
        pos_reg     <= pos_next;
        dc_reg      <= dc_next;
        if (res_push)
        begin
            res_q_reg[res_wp_reg] <= res_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            axis_mem[count_reg[AW-1:0]] <= cmd.axis;
            dep_mem[count_reg[AW-1:0]]  <= cmd.dep;
        end
        axis_q <= axis_mem[rd_addr];
        dep_q  <= dep_mem[rd_addr];
    end

endmodule

// ===== hw/rtl/ngr_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the nearest grid resampler, bound to the top level.
module ngr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              push,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic signed [ngr_pkg::DATA_W-1:0] nearest_axis,
    input logic signed [ngr_pkg::DATA_W-1:0] nearest_dependent,
    input logic [1:0]                        status
);

    // an error result carries zero payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ngr_pkg::ST_OK) |->
            (nearest_axis == '0 && nearest_dependent == '0))
        else $error("error result with nonzero payload");

    // a waiting result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(nearest_axis) && $stable(status)))
        else $error("waiting result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !full)
        else $error("command queue full after reset");

endmodule

bind nearest_grid_resampler ngr_checker u_ngr_checker (.*);
